// File: design/rvm_pkg.sv
// Shared types, opcodes and constants of the register VM executor.
package rvm_pkg;

    localparam int FUNC_W   = 6;
    localparam int DCNT_W   = 11;
    localparam int WORD_W   = 32;
    localparam int CADDR_W  = 12;
    localparam int ERR_W    = 2;
    localparam int ADDR_EXT = 16;   // widest code address the parameters allow
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int DEF_REG_COUNT    = 16;
    localparam int DEF_STACK_DEPTH  = 1024;
    localparam int DEF_RETURN_DEPTH = 64;
    localparam int DEF_CODE_DEPTH   = 4096;
    localparam int DEF_GLOBAL_COUNT = 256;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = 6;

    // register index on the configuration port
    localparam logic REG_ENTRY = 1'b0;

    localparam logic [FUNC_W-1:0] OP_MOV_V      = 6'd0;
    localparam logic [FUNC_W-1:0] OP_MOV_R      = 6'd1;
    localparam logic [FUNC_W-1:0] OP_MOV_S      = 6'd2;
    localparam logic [FUNC_W-1:0] OP_MOV_FLAG   = 6'd3;
    localparam logic [FUNC_W-1:0] OP_ADD        = 6'd4;
    localparam logic [FUNC_W-1:0] OP_ADD_V      = 6'd5;
    localparam logic [FUNC_W-1:0] OP_SUB        = 6'd6;
    localparam logic [FUNC_W-1:0] OP_SUB_V      = 6'd7;
    localparam logic [FUNC_W-1:0] OP_SUB_V_R0   = 6'd8;
    localparam logic [FUNC_W-1:0] OP_SUB_V_R1   = 6'd9;
    localparam logic [FUNC_W-1:0] OP_MUL        = 6'd10;
    localparam logic [FUNC_W-1:0] OP_MUL_V      = 6'd11;
    localparam logic [FUNC_W-1:0] OP_DIV        = 6'd12;
    localparam logic [FUNC_W-1:0] OP_DIV_V      = 6'd13;
    localparam logic [FUNC_W-1:0] OP_LT         = 6'd14;
    localparam logic [FUNC_W-1:0] OP_LT_V       = 6'd15;
    localparam logic [FUNC_W-1:0] OP_LE         = 6'd16;
    localparam logic [FUNC_W-1:0] OP_LE_V       = 6'd17;
    localparam logic [FUNC_W-1:0] OP_GT         = 6'd18;
    localparam logic [FUNC_W-1:0] OP_GT_V       = 6'd19;
    localparam logic [FUNC_W-1:0] OP_GE         = 6'd20;
    localparam logic [FUNC_W-1:0] OP_GE_V       = 6'd21;
    localparam logic [FUNC_W-1:0] OP_EQ         = 6'd22;
    localparam logic [FUNC_W-1:0] OP_EQ_V       = 6'd23;
    localparam logic [FUNC_W-1:0] OP_LD_G       = 6'd24;
    localparam logic [FUNC_W-1:0] OP_ST_G       = 6'd25;
    localparam logic [FUNC_W-1:0] OP_CMP        = 6'd26;
    localparam logic [FUNC_W-1:0] OP_JMP        = 6'd27;
    localparam logic [FUNC_W-1:0] OP_PUSH       = 6'd28;
    localparam logic [FUNC_W-1:0] OP_POP        = 6'd29;
    localparam logic [FUNC_W-1:0] OP_CALL       = 6'd30;
    localparam logic [FUNC_W-1:0] OP_RET        = 6'd31;
    localparam logic [FUNC_W-1:0] OP_PRINT_I    = 6'd32;
    localparam logic [FUNC_W-1:0] OP_PRINT_TNIL = 6'd33;
    localparam logic [FUNC_W-1:0] OP_END        = 6'd34;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DSTK = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RSTK = 2'd3;

    typedef struct packed {
        logic clearing;
        logic ready;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic accept;
        logic need_mul;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: design/rvm_in_if.sv
// Instruction item channel.
interface rvm_in_if;
    import rvm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic [DCNT_W-1:0]         dest_or_count;
    logic signed [WORD_W-1:0]  operand;
    logic [CADDR_W-1:0]        taken_target;
    logic [CADDR_W-1:0]        fallthrough_target;

    modport source (output valid, func, dest_or_count, operand, taken_target,
                    fallthrough_target, input ready);
    modport sink (input valid, func, dest_or_count, operand, taken_target,
                  fallthrough_target, output ready);
endinterface

// File: design/rvm_out_if.sv
// Result item channel.
interface rvm_out_if;
    import rvm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CADDR_W-1:0]        next_pc;
    logic                      print_valid;
    logic                      print_is_bool;
    logic signed [WORD_W-1:0]  print_value;
    logic                      halted;
    logic [ERR_W-1:0]          error_code;

    modport source (output valid, next_pc, print_valid, print_is_bool, print_value,
                    halted, error_code, input ready);
    modport sink (input valid, next_pc, print_valid, print_is_bool, print_value,
                  halted, error_code, output ready);
endinterface

// File: design/rvm_ctrl.sv
// Sequencer: clear pass, accept, execute, multiply and divide waits.
module rvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rvm_pkg::t_status i_status,
    output rvm_pkg::t_cmd    o_cmd
);
    import rvm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MUL   = 5'b01000,
        S_DIV   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clearing = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_status.accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.need_mul) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = S_MUL;
                end else if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done && i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

// File: design/rvm_dpath.sv
// Datapath: register file, stacks, globals, mul/div unit, result register.
module rvm_dpath #(
    parameter int REG_COUNT    = rvm_pkg::DEF_REG_COUNT,
    parameter int STACK_DEPTH  = rvm_pkg::DEF_STACK_DEPTH,
    parameter int RETURN_DEPTH = rvm_pkg::DEF_RETURN_DEPTH,
    parameter int CODE_DEPTH   = rvm_pkg::DEF_CODE_DEPTH,
    parameter int GLOBAL_COUNT = rvm_pkg::DEF_GLOBAL_COUNT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rvm_pkg::t_cmd                i_cmd,
    output rvm_pkg::t_status             o_status,
    input  logic                         i_cfg_we,
    input  logic [rvm_pkg::CADDR_W-1:0]  i_cfg_entry,
    output logic [rvm_pkg::CADDR_W-1:0]  o_entry,
    rvm_in_if.sink                       i_in,
    rvm_out_if.source                    o_out
);
    import rvm_pkg::*;

    // counts and code depth are powers of two; indexes wrap on the low bits
    localparam int RI_W  = $clog2(REG_COUNT);
    localparam int DSP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int RSI_W = $clog2(RETURN_DEPTH);
    localparam int RSD_W = $clog2(RETURN_DEPTH + 1);
    localparam int PC_W  = $clog2(CODE_DEPTH);
    localparam int GI_W  = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int CLR_N = (STACK_DEPTH > GLOBAL_COUNT) ? STACK_DEPTH : GLOBAL_COUNT;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int SUM_W = ((DSP_W > DCNT_W) ? DSP_W : DCNT_W) + 1;
    localparam int SAD_W = WORD_W + 2;

    // storage
    logic [WORD_W-1:0]  rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [WORD_W-1:0]  ds_mem [STACK_DEPTH];
    logic [WORD_W-1:0]  gs_mem [GLOBAL_COUNT];
    logic [PC_W-1:0]    rs_mem [RETURN_DEPTH];

    // architectural state
    logic [CADDR_W-1:0] r_entry;
    logic [PC_W-1:0]    r_pc;
    logic               r_flag;
    logic [DSP_W-1:0]   r_dsp;
    logic [RSD_W-1:0]   r_rdepth;
    logic               r_halt;
    logic [ERR_W-1:0]   r_lerr;
    logic [CLR_W-1:0]   r_clr;

    // latched instruction and operands
    logic [FUNC_W-1:0]        r_func;
    logic [DCNT_W-1:0]        r_d;
    logic signed [WORD_W-1:0] r_op;
    logic [PC_W-1:0]          r_tt, r_ft;
    logic [RI_W-1:0]          r_wi;
    logic [GI_W-1:0]          r_gidx;
    logic                     r_sfault;
    logic signed [WORD_W-1:0] r_a, r_b;
    logic [WORD_W-1:0]        r_sdata, r_gdata;
    logic [PC_W-1:0]          r_rdata;

    // multiply / divide
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_rem, r_dq, r_dvs;
    logic              r_qneg;
    logic [DIV_CW-1:0] r_cnt;

    // output register
    logic               r_ov;
    logic [CADDR_W-1:0] r_o_pc;
    logic               r_o_pv, r_o_pb, r_o_halt;
    logic [WORD_W-1:0]  r_o_val;
    logic [ERR_W-1:0]   r_o_err;

    logic accept, out_free;
    assign i_in.ready = i_cmd.ready;
    assign accept     = i_in.valid && i_cmd.ready;
    assign out_free   = !r_ov || o_out.ready;
    assign o_entry    = r_entry;

    // accept-time address decode
    logic [RI_W-1:0]    in_rd, in_rs, in_wi;
    logic [SAD_W-1:0]   sad;
    logic               s_ok;
    logic [SA_W-1:0]    s_raddr;
    logic [GI_W-1:0]    in_gidx;
    logic [ADDR_EXT-1:0] in_tt16, in_ft16;

    always_comb begin
        in_rd = i_in.dest_or_count[RI_W-1:0];
        in_rs = i_in.operand[RI_W-1:0];
        if (i_in.func == OP_SUB_V_R0) begin
            in_wi = RI_W'(0);
        end else if (i_in.func == OP_SUB_V_R1) begin
            in_wi = RI_W'(1);
        end else begin
            in_wi = in_rd;
        end
        sad = SAD_W'(r_dsp) + {{2{i_in.operand[WORD_W-1]}}, i_in.operand};
        s_ok = !sad[SAD_W-1] && (sad < SAD_W'(STACK_DEPTH));
        s_raddr = (i_in.func == OP_MOV_S) ? sad[SA_W-1:0] : r_dsp[SA_W-1:0];
        in_gidx = (GLOBAL_COUNT > 1) ? i_in.operand[GI_W-1:0] : '0;
        in_tt16 = ADDR_EXT'(i_in.taken_target);
        in_ft16 = ADDR_EXT'(i_in.fallthrough_target);
    end

    // divider step
    logic [WORD_W:0] rem2, rem_n;
    logic            q_bit, div_done;
    always_comb begin
        rem2  = {r_rem, r_dq[WORD_W-1]};
        q_bit = rem2 >= {1'b0, r_dvs};
        rem_n = q_bit ? (rem2 - {1'b0, r_dvs}) : rem2;
    end
    assign div_done = (r_cnt == DIV_CW'(DIV_STEPS));

    // execute
    logic signed [WORD_W-1:0] bsel;
    logic [WORD_W-1:0]  quot, a_mag, d_mag;
    logic [PC_W-1:0]    pc_inc, nxt;
    logic               stop, rf_we, flag_we, flag_nv, ds_we, gs_we, rs_we;
    logic [ERR_W-1:0]   err;
    logic [WORD_W-1:0]  wd;
    logic [DSP_W-1:0]   dsp_nv;
    logic [RSD_W-1:0]   rdep_nv;
    logic               pv, pb;
    logic [WORD_W-1:0]  pval;
    logic [SUM_W-1:0]   ret_sum;
    logic               is_mul, is_div;

    always_comb begin
        bsel   = (r_func[0] == 1'b0) ? r_b : r_op;   // odd codes of ALU pairs take immediate
        if (r_func inside {OP_MUL, OP_DIV}) begin
            bsel = r_b;
        end else if (r_func inside {OP_MUL_V, OP_DIV_V}) begin
            bsel = r_op;
        end
        is_mul = r_func inside {OP_MUL, OP_MUL_V};
        is_div = r_func inside {OP_DIV, OP_DIV_V};
        a_mag  = r_a[WORD_W-1] ? (WORD_W'(0) - r_a) : r_a;
        d_mag  = bsel[WORD_W-1] ? (WORD_W'(0) - bsel) : bsel;
        quot   = r_qneg ? (WORD_W'(0) - r_dq) : r_dq;
        pc_inc = r_pc + PC_W'(1);
        ret_sum = SUM_W'(r_dsp) + SUM_W'(r_d);

        nxt = pc_inc; stop = 1'b0; err = ERR_NONE;
        rf_we = 1'b0; wd = '0; flag_we = 1'b0; flag_nv = 1'b0;
        ds_we = 1'b0; gs_we = 1'b0; rs_we = 1'b0;
        dsp_nv = r_dsp; rdep_nv = r_rdepth;
        pv = 1'b0; pb = 1'b0; pval = '0;

        case (r_func)
            OP_MOV_V: begin rf_we = 1'b1; wd = r_op; end
            OP_MOV_R: begin rf_we = 1'b1; wd = r_b; end
            OP_MOV_S: begin
                if (r_sfault) begin
                    stop = 1'b1; err = ERR_DSTK;
                end else begin
                    rf_we = 1'b1; wd = r_sdata;
                end
            end
            OP_MOV_FLAG: begin flag_we = 1'b1; flag_nv = (r_d != '0); end
            OP_ADD, OP_ADD_V: begin rf_we = 1'b1; wd = r_a + bsel; end
            OP_SUB, OP_SUB_V, OP_SUB_V_R0, OP_SUB_V_R1: begin
                rf_we = 1'b1;
                wd = (r_func == OP_SUB) ? (r_a - r_b) : (r_a - r_op);
            end
            OP_MUL, OP_MUL_V: begin rf_we = 1'b1; wd = r_prod; end
            OP_DIV, OP_DIV_V: begin
                if (bsel == '0) begin
                    stop = 1'b1; err = ERR_DIV0;
                end else begin
                    rf_we = 1'b1; wd = quot;
                end
            end
            OP_LT, OP_LT_V: begin flag_we = 1'b1; flag_nv = r_a < bsel; end
            OP_LE, OP_LE_V: begin flag_we = 1'b1; flag_nv = r_a <= bsel; end
            OP_GT, OP_GT_V: begin flag_we = 1'b1; flag_nv = r_a > bsel; end
            OP_GE, OP_GE_V: begin flag_we = 1'b1; flag_nv = r_a >= bsel; end
            OP_EQ, OP_EQ_V: begin flag_we = 1'b1; flag_nv = r_a == bsel; end
            OP_LD_G: begin rf_we = 1'b1; wd = r_gdata; end
            OP_ST_G: gs_we = 1'b1;
            OP_CMP: nxt = r_flag ? r_tt : r_ft;
            OP_JMP: nxt = r_tt;
            OP_PUSH: begin
                if (r_dsp == '0) begin
                    stop = 1'b1; err = ERR_DSTK;
                end else begin
                    ds_we = 1'b1; dsp_nv = r_dsp - DSP_W'(1);
                end
            end
            OP_POP: begin
                if (r_dsp >= DSP_W'(STACK_DEPTH)) begin
                    stop = 1'b1; err = ERR_DSTK;
                end else begin
                    rf_we = 1'b1; wd = r_sdata; dsp_nv = r_dsp + DSP_W'(1);
                end
            end
            OP_CALL: begin
                if (r_rdepth >= RSD_W'(RETURN_DEPTH)) begin
                    stop = 1'b1; err = ERR_RSTK;
                end else begin
                    rs_we = 1'b1; rdep_nv = r_rdepth + RSD_W'(1); nxt = r_tt;
                end
            end
            OP_RET: begin
                if (r_rdepth == '0) begin
                    stop = 1'b1; err = ERR_RSTK;
                end else if (ret_sum > SUM_W'(STACK_DEPTH)) begin
                    stop = 1'b1; err = ERR_DSTK;
                end else begin
                    dsp_nv = ret_sum[DSP_W-1:0];
                    rdep_nv = r_rdepth - RSD_W'(1);
                    nxt = r_rdata;
                end
            end
            OP_PRINT_I: begin pv = 1'b1; pval = r_a; end
            OP_PRINT_TNIL: begin pv = 1'b1; pb = 1'b1; pval = WORD_W'(r_flag); end
            default: stop = 1'b1;   // end and undefined codes
        endcase
    end

    assign o_status.clear_done = (r_clr == CLR_W'(CLR_N - 1));
    assign o_status.accept     = accept;
    assign o_status.need_mul   = !r_halt && is_mul;
    assign o_status.need_div   = !r_halt && is_div && (bsel != '0);
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = out_free;

    logic commit_ok;
    assign commit_ok = i_cmd.commit && !r_halt && !stop;

    // register file: two read ports at accept, one write at commit
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= r_rf_vld[in_wi] ? rf_mem[in_wi] : '0;
            r_b <= r_rf_vld[in_rs] ? rf_mem[in_rs] : '0;
        end
        if (commit_ok && rf_we) begin
            rf_mem[r_wi] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (commit_ok && rf_we) begin
            r_rf_vld[r_wi] <= 1'b1;
        end
    end

    // data stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.clearing && ({1'b0, r_clr} < (CLR_W + 1)'(STACK_DEPTH))) begin
            ds_mem[r_clr[SA_W-1:0]] <= '0;
        end else if (commit_ok && ds_we) begin
            ds_mem[dsp_nv[SA_W-1:0]] <= r_a;
        end
        if (accept) begin
            r_sdata <= ds_mem[s_raddr];
        end
    end

    // global store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clearing && ({1'b0, r_clr} < (CLR_W + 1)'(GLOBAL_COUNT))) begin
            gs_mem[(GLOBAL_COUNT > 1) ? r_clr[GI_W-1:0] : '0] <= '0;
        end else if (commit_ok && gs_we) begin
            gs_mem[r_gidx] <= r_a;
        end
        if (accept) begin
            r_gdata <= gs_mem[in_gidx];
        end
    end

    // return-address stack
    always_ff @(posedge i_clk) begin
        if (commit_ok && rs_we) begin
            rs_mem[r_rdepth[RSI_W-1:0]] <= pc_inc;
        end
        if (accept) begin
            r_rdata <= rs_mem[RSI_W'(r_rdepth - RSD_W'(1))];
        end
    end

    // instruction latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_in.func;
            r_d      <= i_in.dest_or_count;
            r_op     <= i_in.operand;
            r_tt     <= in_tt16[PC_W-1:0];
            r_ft     <= in_ft16[PC_W-1:0];
            r_wi     <= in_wi;
            r_gidx   <= in_gidx;
            r_sfault <= !s_ok;
        end
    end

    // multiply and divide unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_prod <= WORD_W'(r_a * bsel);
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dq   <= a_mag;
            r_dvs  <= d_mag;
            r_qneg <= r_a[WORD_W-1] ^ bsel[WORD_W-1];
        end else if (i_cmd.div_step && !div_done) begin
            r_rem <= rem_n[WORD_W-1:0];
            r_dq  <= {r_dq[WORD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= '0;
        end else if (i_cmd.div_step && !div_done) begin
            r_cnt <= r_cnt + DIV_CW'(1);
        end
    end

    // architectural control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= '0;
            r_pc     <= '0;
            r_flag   <= 1'b0;
            r_dsp    <= DSP_W'(STACK_DEPTH);
            r_rdepth <= '0;
            r_halt   <= 1'b0;
            r_lerr   <= ERR_NONE;
            r_clr    <= '0;
        end else begin
            if (i_cmd.clearing && !o_status.clear_done) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_cfg_we) begin
                r_entry <= i_cfg_entry;
                r_pc    <= PC_W'(ADDR_EXT'(i_cfg_entry));
            end else if (i_cmd.commit && !r_halt) begin
                if (stop) begin
                    r_halt <= 1'b1;
                    r_lerr <= err;
                end else begin
                    r_pc     <= nxt;
                    r_dsp    <= dsp_nv;
                    r_rdepth <= rdep_nv;
                    if (flag_we) begin
                        r_flag <= flag_nv;
                    end
                end
            end
        end
    end

    // result register
    logic [ADDR_EXT-1:0] out_pc16;
    assign out_pc16 = (r_halt || stop) ? ADDR_EXT'(r_pc) : ADDR_EXT'(nxt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_pc   <= out_pc16[CADDR_W-1:0];
            r_o_pv   <= !r_halt && pv;
            r_o_pb   <= !r_halt && pb;
            r_o_val  <= r_halt ? '0 : pval;
            r_o_halt <= r_halt || stop;
            r_o_err  <= r_halt ? r_lerr : (stop ? err : ERR_NONE);
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.next_pc       = r_o_pc;
    assign o_out.print_valid   = r_o_pv;
    assign o_out.print_is_bool = r_o_pb;
    assign o_out.print_value   = r_o_val;
    assign o_out.halted        = r_o_halt;
    assign o_out.error_code    = r_o_err;
endmodule

// File: design/register_vm_instruction_execute.sv
// Top level of the register VM instruction executor.
//
//  channel   dir  handshake          contents
//  i_in      in   valid/ready        func, dest_or_count, operand, targets
//  o_out     out  valid/ready        next_pc, print fields, halted, error_code
//  apb       in   psel/penable/...   entry_address at byte 0
//
// Most items pass through accept and execute; multiply adds a wait for the registered
// 32x32 product; divide steps through the one-bit-per-cycle restoring divider.
// After reset a clearing pass over max(STACK_DEPTH, GLOBAL_COUNT) entries (1024 by
// default) zeroes the data stack and globals; no item is accepted meanwhile.
// A result waits in the output register; execute holds while it is not taken.
module register_vm_instruction_execute #(
    parameter int REG_COUNT    = rvm_pkg::DEF_REG_COUNT,
    parameter int STACK_DEPTH  = rvm_pkg::DEF_STACK_DEPTH,
    parameter int RETURN_DEPTH = rvm_pkg::DEF_RETURN_DEPTH,
    parameter int CODE_DEPTH   = rvm_pkg::DEF_CODE_DEPTH,
    parameter int GLOBAL_COUNT = rvm_pkg::DEF_GLOBAL_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rvm_in_if.sink                      i_in,
    rvm_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rvm_pkg::APB_AW-1:0]  paddr,
    input  logic [rvm_pkg::APB_DW-1:0]  pwdata,
    output logic [rvm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rvm_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic              cfg_we;
    logic [CADDR_W-1:0] entry;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_ENTRY);
    assign prdata = (paddr[APB_AW-1] == REG_ENTRY) ? APB_DW'(entry) : '0;

    rvm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rvm_dpath #(
        .REG_COUNT    (REG_COUNT),
        .STACK_DEPTH  (STACK_DEPTH),
        .RETURN_DEPTH (RETURN_DEPTH),
        .CODE_DEPTH   (CODE_DEPTH),
        .GLOBAL_COUNT (GLOBAL_COUNT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (cfg_we),
        .i_cfg_entry (pwdata[CADDR_W-1:0]),
        .o_entry     (entry),
        .i_in        (i_in),
        .o_out       (o_out)
    );
endmodule
